[src/sfd_pkg.sv]
// Shared types and constants for the SBUS frame decoder.
// No dependencies; imported by every module of the block.
package sfd_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int BUFFER_BYTES = 36;
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

	localparam int CH_W      = 11;
	localparam int NUM_CH    = 10;
	localparam int NUM_STICK = 6;
	localparam int NUM_SW    = NUM_CH - NUM_STICK;
	localparam int CH_BITS   = NUM_CH * CH_W;

	localparam int DECODE_BYTES = 1 + (CH_BITS + 7) / 8;
	localparam int PAYLOAD_W    = (DECODE_BYTES - 1) * 8;
	localparam int IDX_W        = $clog2(DECODE_BYTES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SBUS_HEADER = 8'h0F;

	localparam logic [CH_W-1:0] MAX_MAG_RESET  = 11'd660;
	localparam logic [CH_W-1:0] DEADBAND_RESET = 11'd10;

	typedef enum logic {
		REG_MAX_MAG  = 1'b0,
		REG_DEADBAND = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_ACCEPT  = 2'd0,
		ST_REJECT  = 2'd1,
		ST_BAD_HDR = 2'd2
	} status_t;

	typedef struct packed {
		logic               hdr_ok;
		logic [CH_BITS-1:0] bits;
	} frame_t;

	typedef struct packed {
		logic   push;
		frame_t data;
	} push_t;

endpackage

[src/sfd_front.sv]
// Front end: accepts byte and idle beats, keeps the frame store and byte count,
// and pushes complete frames to the queue. Depends on sfd_pkg.
module sfd_front import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output push_t      q_push
);

	logic [7:0]           store_q [DECODE_BYTES];
	logic [CNT_W-1:0]     cnt_q;
	logic                 accept;
	logic [PAYLOAD_W-1:0] payload;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (mode) begin
				cnt_q <= '0;
			end else if (cnt_q < CNT_W'(BUFFER_BYTES)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !mode && (cnt_q < CNT_W'(DECODE_BYTES))) begin
			store_q[cnt_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	always_comb begin
		payload = '0;
		for (int i = 1; i < DECODE_BYTES; i++) begin
			payload[(i-1)*8 +: 8] = store_q[i];
		end
	end

	always_comb begin
		q_push.push        = accept && mode && (cnt_q == CNT_W'(FRAME_BYTES));
		q_push.data.hdr_ok = (store_q[0] == SBUS_HEADER);
		q_push.data.bits   = payload[CH_BITS-1:0];
	end

endmodule

[src/sfd_queue.sv]
// Two-entry frame queue between front and back ends.
// Depends on sfd_pkg.
module sfd_queue import sfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  q_push,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output frame_t head
);

	frame_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = q_push.push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_push.data;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("frame queue count beyond depth");
`endif

endmodule

[src/sfd_back.sv]
// Back end: unpacks queued frames, centers and deadbands sticks, checks range,
// keeps current values and the output register. Depends on sfd_pkg.
module sfd_back import sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CH_W-1:0]        cfg_data,
	input  logic                   q_valid,
	input  frame_t                 q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [CH_W-1:0] out_stick [NUM_STICK],
	output logic [CH_W-1:0]        out_switch [NUM_SW],
	output status_t                out_status
);

	logic [CH_W-1:0]        max_mag_q;
	logic [CH_W-1:0]        deadband_q;

	logic                   valid_s1;
	frame_t                 frame_s1;

	logic signed [CH_W-1:0] cur_stick_q [NUM_STICK];
	logic [CH_W-1:0]        cur_sw_q [NUM_SW];

	logic                   out_valid_q;
	logic signed [CH_W-1:0] out_stick_q [NUM_STICK];
	logic [CH_W-1:0]        out_sw_q [NUM_SW];
	status_t                out_status_q;

	logic [CH_W-1:0]        raw [NUM_CH];
	logic signed [CH_W-1:0] ctr [NUM_STICK];
	logic [CH_W:0]          mag [NUM_STICK];
	logic                   in_db [NUM_STICK];
	logic signed [CH_W-1:0] stick_val [NUM_STICK];
	logic                   reject;
	logic                   out_load;
	logic                   load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mag_q  <= MAX_MAG_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_MAG:  max_mag_q  <= cfg_data;
				REG_DEADBAND: deadband_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign load_s1  = q_valid && (!valid_s1 || out_load);
	assign q_pop    = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load_s1 || (valid_s1 && !out_load);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			frame_s1 <= q_head;
		end
	end

	always_comb begin
		reject = 1'b0;
		for (int k = 0; k < NUM_CH; k++) begin
			raw[k] = frame_s1.bits[k*CH_W +: CH_W];
		end
		for (int k = 0; k < NUM_STICK; k++) begin
			ctr[k]   = $signed({~raw[k][CH_W-1], raw[k][CH_W-2:0]});
			mag[k]   = ctr[k][CH_W-1] ? ((CH_W+1)'(0) - {ctr[k][CH_W-1], ctr[k]})
			                          : {1'b0, ctr[k]};
			in_db[k] = (mag[k] <= {1'b0, deadband_q});
			stick_val[k] = in_db[k] ? '0 : ctr[k];
			if (!in_db[k] && (mag[k] > {1'b0, max_mag_q})) begin
				reject = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STICK; k++) cur_stick_q[k] <= '0;
			for (int k = 0; k < NUM_SW; k++) cur_sw_q[k] <= '0;
		end else if (out_load && frame_s1.hdr_ok) begin
			for (int k = 0; k < NUM_STICK; k++) begin
				cur_stick_q[k] <= reject ? '0 : stick_val[k];
			end
			for (int k = 0; k < NUM_SW; k++) begin
				cur_sw_q[k] <= reject ? '0 : raw[NUM_STICK + k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!frame_s1.hdr_ok) begin
				out_stick_q  <= cur_stick_q;
				out_sw_q     <= cur_sw_q;
				out_status_q <= ST_BAD_HDR;
			end else if (reject) begin
				for (int k = 0; k < NUM_STICK; k++) out_stick_q[k] <= '0;
				for (int k = 0; k < NUM_SW; k++) out_sw_q[k] <= '0;
				out_status_q <= ST_REJECT;
			end else begin
				out_stick_q <= stick_val;
				for (int k = 0; k < NUM_SW; k++) out_sw_q[k] <= raw[NUM_STICK + k];
				out_status_q <= ST_ACCEPT;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_stick  = out_stick_q;
	assign out_switch = out_sw_q;
	assign out_status = out_status_q;

`ifndef SYNTH
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_REJECT) |->
		(out_stick_q[0] == '0 && out_stick_q[3] == '0 && out_sw_q[0] == '0 &&
		 cur_stick_q[0] == '0 && cur_sw_q[NUM_SW-1] == '0))
		else $error("rejected frame carries nonzero values");
`endif
`ifndef SYNTH
	a_bad_hdr_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_BAD_HDR) |->
		(out_stick_q[0] == cur_stick_q[0] && out_sw_q[0] == cur_sw_q[0]))
		else $error("bad header frame does not repeat current values");
`endif
`ifndef SYNTH
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_load) |=> (valid_s1 && $stable(frame_s1)))
		else $error("decode stage lost a stalled frame");
`endif

endmodule

[src/sbus_frame_decoder_unit.sv]
// Top level of the SBUS frame decoder: front end, frame queue and back end.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_ready  mode, rx_byte
//  out      out_valid/out_ready  stick_1..4, knob_1..2, switch_1..4,
//                                frame_status
//  cfg      cfg_we               cfg_index, cfg_data
//
// One beat per cycle on the input while in_ready is high; a frame result passes
// through the queue, decode register and output register after its idle beat.
// in_ready drops only while the two-entry frame queue is full.
// Reset clears byte count, current values and config to their defaults.
module sbus_frame_decoder_unit import sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CH_W-1:0]        cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [CH_W-1:0] stick_1,
	output logic signed [CH_W-1:0] stick_2,
	output logic signed [CH_W-1:0] stick_3,
	output logic signed [CH_W-1:0] stick_4,
	output logic signed [CH_W-1:0] knob_1,
	output logic signed [CH_W-1:0] knob_2,
	output logic [CH_W-1:0]        switch_1,
	output logic [CH_W-1:0]        switch_2,
	output logic [CH_W-1:0]        switch_3,
	output logic [CH_W-1:0]        switch_4,
	output logic [1:0]             frame_status
);

	push_t                  q_push;
	logic                   q_full;
	logic                   q_valid;
	logic                   q_pop;
	frame_t                 q_head;
	logic signed [CH_W-1:0] stick [NUM_STICK];
	logic [CH_W-1:0]        sw [NUM_SW];
	status_t                status;

	sfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push)
	);

	sfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_push    (q_push),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	sfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_stick  (stick),
		.out_switch (sw),
		.out_status (status)
	);

	assign stick_1      = stick[0];
	assign stick_2      = stick[1];
	assign stick_3      = stick[2];
	assign stick_4      = stick[3];
	assign knob_1       = stick[4];
	assign knob_2       = stick[5];
	assign switch_1     = sw[0];
	assign switch_2     = sw[1];
	assign switch_3     = sw[2];
	assign switch_4     = sw[3];
	assign frame_status = status;

endmodule
